// ----- design/blr_pkg.sv -----
package blr_pkg;

  // Fixed field widths of the line command and the pixel result.
  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;
  localparam int CANVAS_W = 7;
  localparam int CFG_ADDR_W = 1;

  // Error term and its doubled form, wide enough for any octant on the grid.
  localparam int ERR_W = COORD_W + 3;
  localparam int E2_W = ERR_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_WIDTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  // Reset value of both canvas dimensions.
  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } blr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;
  } blr_sts_t;

endpackage

// ----- design/blr_ctrl.sv -----
module blr_ctrl
  import blr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output blr_cmd_t cmd,
  input  blr_sts_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DRAW = 1'b1;

  logic state_r;
  logic state_nxt;

  // Handshake outputs follow the state directly.
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_DRAW);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.step   = out_tvalid && out_tready;

  // Idle waits for a command; draw walks the line one pixel per transfer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (cmd.step && sts.at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/blr_datapath.sv -----
module blr_datapath
  import blr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  blr_cmd_t              cmd,
  output blr_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CANVAS_W-1:0]   cfg_wdata,
  input  logic [COORD_W-1:0]    start_x,
  input  logic [COORD_W-1:0]    start_y,
  input  logic [COORD_W-1:0]    end_x,
  input  logic [COORD_W-1:0]    end_y,
  input  logic [COLOR_W-1:0]    color,
  output logic [COORD_W-1:0]    pixel_x,
  output logic [COORD_W-1:0]    pixel_y,
  output logic [COLOR_W-1:0]    pixel_color,
  output logic                  visible,
  output logic                  last
);

  localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIZE - 1);

  logic [CANVAS_W-1:0] canvas_w_r;
  logic [CANVAS_W-1:0] canvas_h_r;

  logic [COORD_W-1:0] x_r, y_r, xe_r, ye_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic               sx_neg_r, sy_neg_r;
  logic [ERR_W-1:0]   err_r;
  logic [COLOR_W-1:0] color_r;

  logic [COORD_W-1:0] cx0, cy0, cx1, cy1;
  logic [COORD_W-1:0] ldx, ldy;
  logic signed [E2_W-1:0] e2, neg_dy, pos_dx;
  logic               move_x, move_y;
  logic [ERR_W-1:0]   err_nxt;

  // Canvas size registers; writes to other indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= CANVAS_RESET;
      canvas_h_r <= CANVAS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CANVAS_WIDTH:  canvas_w_r <= cfg_wdata;
        REG_CANVAS_HEIGHT: canvas_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate endpoints to the grid and form the deltas for the load.
  assign cx0 = (start_x > MAX_COORD) ? MAX_COORD : start_x;
  assign cy0 = (start_y > MAX_COORD) ? MAX_COORD : start_y;
  assign cx1 = (end_x > MAX_COORD) ? MAX_COORD : end_x;
  assign cy1 = (end_y > MAX_COORD) ? MAX_COORD : end_y;
  assign ldx = (cx1 > cx0) ? (cx1 - cx0) : (cx0 - cx1);
  assign ldy = (cy1 > cy0) ? (cy1 - cy0) : (cy0 - cy1);

  // One Bresenham step: compare the doubled error against both deltas.
  assign e2     = {err_r[ERR_W-1], err_r} <<< 1;
  assign neg_dy = -$signed({{(E2_W-COORD_W){1'b0}}, dy_r});
  assign pos_dx = $signed({{(E2_W-COORD_W){1'b0}}, dx_r});
  assign move_x = (e2 > neg_dy);
  assign move_y = (e2 < pos_dx);
  assign err_nxt = err_r
                 - (move_x ? {{(ERR_W-COORD_W){1'b0}}, dy_r} : {ERR_W{1'b0}})
                 + (move_y ? {{(ERR_W-COORD_W){1'b0}}, dx_r} : {ERR_W{1'b0}});

  // Walker registers: loaded by a command, advanced on each pixel transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= cx0;
      y_r      <= cy0;
      xe_r     <= cx1;
      ye_r     <= cy1;
      dx_r     <= ldx;
      dy_r     <= ldy;
      sx_neg_r <= !(cx0 < cx1);
      sy_neg_r <= !(cy0 < cy1);
      err_r    <= {{(ERR_W-COORD_W){1'b0}}, ldx} - {{(ERR_W-COORD_W){1'b0}}, ldy};
      color_r  <= color;
    end else if (cmd.step) begin
      err_r <= err_nxt;
      if (move_x) begin
        x_r <= sx_neg_r ? (x_r - 1'b1) : (x_r + 1'b1);
      end
      if (move_y) begin
        y_r <= sy_neg_r ? (y_r - 1'b1) : (y_r + 1'b1);
      end
    end
  end

  // Current pixel and its flags.
  assign last        = (x_r == xe_r) && (y_r == ye_r);
  assign sts.at_end  = last;
  assign pixel_x     = x_r;
  assign pixel_y     = y_r;
  assign pixel_color = color_r;
  assign visible     = ({1'b0, x_r} < canvas_w_r) && ({1'b0, y_r} < canvas_h_r);

endmodule

// ----- design/bresenham_line_rasterizer_core.sv -----
// The first pixel is offered in the cycle after a command transfer.
// A command is loaded on its transfer, then the single error-term stepper gives
// max(dx,dy)+1 pixels at one pixel per cycle while out_tready is high.
// Reset (synchronous, active low) returns the controller to idle and sets
// the canvas to 64 columns by 64 rows.
module bresenham_line_rasterizer_core
  import blr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], color[31:24]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,
  // out_tdata: pixel_x[5:0], pixel_y[11:6], pixel_color[19:12], zero fill[23:20]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,
  // out_tuser: visible[0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CANVAS_W-1:0]   cfg_wdata
);

  blr_cmd_t cmd;
  blr_sts_t sts;

  logic [COORD_W-1:0] pixel_x, pixel_y;
  logic [COLOR_W-1:0] pixel_color;

  blr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  blr_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .start_x     (in_tdata[5:0]),
    .start_y     (in_tdata[11:6]),
    .end_x       (in_tdata[17:12]),
    .end_y       (in_tdata[23:18]),
    .color       (in_tdata[31:24]),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .visible     (out_tuser),
    .last        (out_tlast)
  );

  assign out_tdata = {4'b0000, pixel_color, pixel_y, pixel_x};

  // A command is never taken while a line is still being drawn.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("command accepted during drawing");

  // A command transfer starts the pixel stream on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("no pixel after command");

  // Transferring the end point returns the block to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("not idle after last pixel");

  // A pixel that is not the end point keeps the stream going.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("stream stopped before end point");

endmodule
